/* rtl/clni_pkg.sv */
// shared types, codes and constants for the character lcd nibble interface
`timescale 1ns / 1ps
`default_nettype none
package clni_pkg;

  localparam int OP_W      = 3;
  localparam int VALUE_W   = 32;
  localparam int LINE_W    = 2;
  localparam int POS_W     = 5;
  localparam int NIBBLE_W  = 4;
  localparam int WAIT_W    = 5;
  localparam int BYTE_W    = 8;

  localparam int NUM_CFG   = 6;
  localparam int CFG_IDX_W = 3;

  localparam logic [OP_W-1:0] OP_INIT   = 3'd0;
  localparam logic [OP_W-1:0] OP_CMD    = 3'd1;
  localparam logic [OP_W-1:0] OP_DATA   = 3'd2;
  localparam logic [OP_W-1:0] OP_CURSOR = 3'd3;
  localparam logic [OP_W-1:0] OP_NUMBER = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_FUNC_SET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DISP_CTL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLEAR    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LINE0    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LINE1    = 3'd5;

  localparam logic [BYTE_W-1:0] CFG_RESET [NUM_CFG] =
    '{8'd40, 8'd12, 8'd1, 8'd6, 8'd128, 8'd192};

  localparam logic [WAIT_W-1:0] INIT_WAIT   = 5'd30;
  localparam logic [WAIT_W-1:0] STROBE_WAIT = 5'd2;
  localparam logic [WAIT_W-1:0] WAIT_NONE   = 5'd0;
  localparam logic [WAIT_W-1:0] WAIT_ONE    = 5'd1;

  localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;
  localparam int NUM_DIGITS  = 10;
  localparam int DIGIT_W     = 4;
  localparam int BCD_W       = NUM_DIGITS * DIGIT_W;
  localparam int DIGIT_IDX_W = $clog2(NUM_DIGITS);
  localparam int DABBLE_W    = $clog2(VALUE_W);
  localparam int NUM_COLS    = 16;
  localparam int NUM_LINES   = 2;

  localparam int QDEPTH  = 4;
  localparam int QADDR_W = $clog2(QDEPTH);

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [VALUE_W-1:0] value;
    logic [LINE_W-1:0]  line;
    logic [POS_W-1:0]   position;
  } clni_in_t;

  typedef struct packed {
    logic                register_select;
    logic                enable;
    logic [NIBBLE_W-1:0] data_nibble;
    logic [WAIT_W-1:0]   wait_ticks;
    logic                last;
  } clni_out_t;

  // one byte (or lone high nibble) for the pin sequencer
  typedef struct packed {
    logic              rs;
    logic [BYTE_W-1:0] cmd_byte;
    logic [WAIT_W-1:0] pre_wait;
    logic              last;
    logic              strobe_only;
  } clni_job_t;

endpackage
`default_nettype wire

/* rtl/clni_front.sv */
// request decoder: config registers, init sequencing, decimal conversion, job issue
`timescale 1ns / 1ps
`default_nettype none
module clni_front
  import clni_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire clni_in_t             in_payload,
  input  wire logic                 cfg_write_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [BYTE_W-1:0]    cfg_data,
  output logic                      push_valid,
  input  wire logic                 push_ready,
  output clni_job_t                 push_job
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_INIT   = 3'd1;
  localparam logic [2:0] ST_SINGLE = 3'd2;
  localparam logic [2:0] ST_DABBLE = 3'd3;
  localparam logic [2:0] ST_EMIT   = 3'd4;

  logic [2:0]             state_r, state_nxt;
  logic [2:0]             step_r, step_nxt;
  logic [DABBLE_W-1:0]    cnt_r, cnt_nxt;
  logic [DIGIT_IDX_W-1:0] idx_r, idx_nxt;
  logic                   started_r, started_nxt;
  logic                   sel_r, sel_nxt;
  logic [VALUE_W-1:0]     bin_r, bin_nxt;
  logic [BCD_W-1:0]       bcd_r, bcd_nxt;
  clni_job_t              job_r, job_nxt;
  logic [BYTE_W-1:0]      cfg_r [NUM_CFG];

  clni_job_t              init_job;
  logic [BCD_W-1:0]       bcd_adj;
  logic [DIGIT_W-1:0]     cur_digit;
  logic [DIGIT_W-1:0]     dig;
  logic                   show;
  logic [BYTE_W-1:0]      base;

  assign in_ready = (state_r == ST_IDLE);

  // config write port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CFG; i++) cfg_r[i] <= CFG_RESET[i];
    end else if (cfg_write_en && (cfg_index < CFG_IDX_W'(NUM_CFG))) begin
      cfg_r[cfg_index] <= cfg_data;
    end
  end

  always_comb begin
    init_job = '0;
    unique case (step_r)
      3'd0: begin
        init_job.rs = sel_r;
        init_job.cmd_byte = cfg_r[REG_FUNC_SET];
        init_job.pre_wait = INIT_WAIT;
        init_job.strobe_only = 1'b1;
      end
      3'd1: begin
        init_job.cmd_byte = cfg_r[REG_FUNC_SET];
        init_job.pre_wait = WAIT_NONE;
      end
      3'd2: begin
        init_job.cmd_byte = cfg_r[REG_DISP_CTL];
        init_job.pre_wait = WAIT_ONE;
      end
      3'd3: begin
        init_job.cmd_byte = cfg_r[REG_CLEAR];
        init_job.pre_wait = WAIT_ONE;
      end
      3'd4: begin
        init_job.cmd_byte = cfg_r[REG_ENTRY];
        init_job.pre_wait = STROBE_WAIT;
        init_job.last = 1'b1;
      end
      default: init_job = '0;
    endcase
  end

  // add-three correction per bcd digit
  always_comb begin
    for (int d = 0; d < NUM_DIGITS; d++) begin
      dig = bcd_r[d*DIGIT_W +: DIGIT_W];
      bcd_adj[d*DIGIT_W +: DIGIT_W] = (dig >= 4'd5) ? (dig + 4'd3) : dig;
    end
  end

  assign cur_digit = bcd_r[idx_r*DIGIT_W +: DIGIT_W];
  assign base = (in_payload.line == LINE_W'(0)) ? cfg_r[REG_LINE0] : cfg_r[REG_LINE1];

  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    cnt_nxt     = cnt_r;
    idx_nxt     = idx_r;
    started_nxt = started_r;
    sel_nxt     = sel_r;
    bin_nxt     = bin_r;
    bcd_nxt     = bcd_r;
    job_nxt     = job_r;
    push_valid  = 1'b0;
    push_job    = '0;
    show        = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          job_nxt = '0;
          job_nxt.last = 1'b1;
          job_nxt.pre_wait = WAIT_NONE;
          job_nxt.cmd_byte = in_payload.value[BYTE_W-1:0];
          unique case (in_payload.operation)
            OP_INIT: begin
              state_nxt = ST_INIT;
              step_nxt  = 3'd0;
            end
            OP_CMD: state_nxt = ST_SINGLE;
            OP_DATA: begin
              job_nxt.rs = 1'b1;
              state_nxt  = ST_SINGLE;
            end
            OP_CURSOR: begin
              job_nxt.cmd_byte = base + BYTE_W'(in_payload.position);
              if ((in_payload.line < LINE_W'(NUM_LINES)) &&
                  (in_payload.position < POS_W'(NUM_COLS))) begin
                state_nxt = ST_SINGLE;
              end
            end
            OP_NUMBER: begin
              bin_nxt   = in_payload.value;
              bcd_nxt   = '0;
              cnt_nxt   = '0;
              state_nxt = ST_DABBLE;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_INIT: begin
        push_valid = 1'b1;
        push_job   = init_job;
        if (push_ready) begin
          step_nxt = step_r + 3'd1;
          if (step_r == 3'd4) state_nxt = ST_IDLE;
        end
      end
      ST_SINGLE: begin
        push_valid = 1'b1;
        push_job   = job_r;
        if (push_ready) state_nxt = ST_IDLE;
      end
      ST_DABBLE: begin
        {bcd_nxt, bin_nxt} = {bcd_adj[BCD_W-2:0], bin_r, 1'b0};
        cnt_nxt = cnt_r + DABBLE_W'(1);
        if (cnt_r == DABBLE_W'(VALUE_W - 1)) begin
          state_nxt   = ST_EMIT;
          idx_nxt     = DIGIT_IDX_W'(NUM_DIGITS - 1);
          started_nxt = 1'b0;
        end
      end
      ST_EMIT: begin
        // leading zeros are skipped, the units digit always goes out
        show = started_r || (cur_digit != '0) || (idx_r == '0);
        push_valid = show;
        push_job.rs = 1'b1;
        push_job.cmd_byte = ASCII_ZERO + BYTE_W'(cur_digit);
        push_job.pre_wait = WAIT_NONE;
        push_job.last = (idx_r == '0);
        if (!show || push_ready) begin
          started_nxt = started_r || show;
          if (idx_r == '0) state_nxt = ST_IDLE;
          else idx_nxt = idx_r - DIGIT_IDX_W'(1);
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (push_valid && push_ready) sel_nxt = push_job.rs;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      step_r    <= '0;
      cnt_r     <= '0;
      idx_r     <= '0;
      started_r <= 1'b0;
      sel_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      step_r    <= step_nxt;
      cnt_r     <= cnt_nxt;
      idx_r     <= idx_nxt;
      started_r <= started_nxt;
      sel_r     <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
    job_r <= job_nxt;
  end

endmodule
`default_nettype wire

/* rtl/clni_queue.sv */
// small job fifo between decoder and pin sequencer
`timescale 1ns / 1ps
`default_nettype none
module clni_queue
  import clni_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push_valid,
  output logic           push_ready,
  input  wire clni_job_t push_job,
  output logic           pop_valid,
  input  wire logic      pop_ready,
  output clni_job_t      pop_job
);

  clni_job_t          mem_r [QDEPTH];
  logic [QADDR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QADDR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QADDR_W:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign push_ready = (count_r != (QADDR_W+1)'(QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_job    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QADDR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QADDR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + (QADDR_W+1)'(do_push) - (QADDR_W+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_job;
  end

endmodule
`default_nettype wire

/* rtl/clni_back.sv */
// pin sequencer: turns each job into timed enable strobes
`timescale 1ns / 1ps
`default_nettype none
module clni_back
  import clni_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      pop_valid,
  output logic           pop_ready,
  input  wire clni_job_t pop_job,
  output logic           out_valid,
  input  wire logic      out_ready,
  output clni_out_t      out_payload
);

  clni_job_t  job_r;
  logic       busy_r, busy_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic       out_valid_r, out_valid_nxt;
  clni_out_t  out_r, out_nxt;
  logic       emit, final_phase;

  assign pop_ready   = !busy_r;
  assign out_valid   = out_valid_r;
  assign out_payload = out_r;

  assign emit = busy_r && (!out_valid_r || out_ready);
  assign final_phase = job_r.strobe_only ? (phase_r == 2'd1) : (phase_r == 2'd3);

  always_comb begin
    busy_nxt      = busy_r;
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    if (!busy_r && pop_valid) begin
      busy_nxt  = 1'b1;
      phase_nxt = 2'd0;
    end
    if (emit) begin
      out_valid_nxt               = 1'b1;
      out_nxt.register_select     = job_r.rs;
      out_nxt.enable              = !phase_r[0];
      out_nxt.data_nibble         = phase_r[1] ? job_r.cmd_byte[3:0] : job_r.cmd_byte[7:4];
      out_nxt.wait_ticks          = phase_r[0] ? STROBE_WAIT
                                  : (phase_r[1] ? WAIT_NONE : job_r.pre_wait);
      out_nxt.last                = final_phase && job_r.last;
      phase_nxt                   = phase_r + 2'd1;
      if (final_phase) busy_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (!busy_r && pop_valid) job_r <= pop_job;
  end

endmodule
`default_nettype wire

/* rtl/char_lcd_nibble_interface.sv */
// top level of the 4-bit character lcd interface
//
// in_* carries one request (init, command, character, cursor, number) per
// transfer; out_* returns timed pin states, one per transfer, with last set
// on the final state of a request that produces any. cfg_* writes one of the
// six command and offset registers; the user must write them only while
// idle, as the block does not enforce it. A request is taken only when the
// decoder is idle, one at a time. Bytes are queued (four deep) to the pin
// sequencer, which emits a byte as four states, one per cycle while the
// receiver takes them, and loads the next byte once the last is out. A
// request passes the decoder, the queue and the sequencer's job register
// before its first state is registered. Init gives 18 states. A number takes
// 32 shift-add steps in the bcd converter, one per cycle, then scans the ten
// digits one per cycle while the queue takes them, skipping leading zeros.
// Cursor requests off the screen and unknown operations give nothing.
// Reset restores the register defaults, empties the queue, drops out_valid
// and sets the remembered select level to command. A stalled receiver holds
// the output register; the queue then fills and the decoder waits.
`timescale 1ns / 1ps
`default_nettype none
module char_lcd_nibble_interface
  import clni_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire clni_in_t             in_payload,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output clni_out_t                 out_payload,
  input  wire logic                 cfg_write_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [BYTE_W-1:0]    cfg_data
);

  logic      push_valid, push_ready, pop_valid, pop_ready;
  clni_job_t push_job, pop_job;

  clni_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_payload   (in_payload),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_job     (push_job)
  );

  clni_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  clni_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_job     (pop_job),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_payload (out_payload)
  );

endmodule
`default_nettype wire

/* rtl/clni_checker.sv */
// port-level checks for the lcd interface, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module clni_checker
  import clni_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire clni_out_t out_payload
);

  logic                prev_en_r;
  logic [NIBBLE_W-1:0] prev_nib_r;
  logic                out_xfer;

  assign out_xfer = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_en_r  <= 1'b0;
      prev_nib_r <= '0;
    end else if (out_xfer) begin
      prev_en_r  <= out_payload.enable;
      prev_nib_r <= out_payload.data_nibble;
    end
  end

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload))
    else $error("result changed while stalled");

  // a raised enable is always dropped next, same nibble, after the strobe wait
  a_strobe_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && prev_en_r |-> !out_payload.enable &&
      out_payload.data_nibble == prev_nib_r && out_payload.wait_ticks == STROBE_WAIT)
    else $error("enable strobe not closed properly");

  // a request never ends with enable high
  a_last_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload.last |-> !out_payload.enable)
    else $error("last state with enable high");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind char_lcd_nibble_interface clni_checker u_clni_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_payload (out_payload)
);
`default_nettype wire

/* verif/char_lcd_nibble_interface_tb.sv */
// self-checking testbench for the 4-bit character lcd interface: table and random requests
`timescale 1ns / 1ps
module char_lcd_nibble_interface_tb;
  import clni_pkg::*;

  localparam int CLK_PERIOD      = 8;
  localparam int RESET_CYCLES    = 6;
  localparam int SETTLE_CYCLES   = 120;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int ITEMS_PER_PHASE = 25;
  localparam int NUM_PHASES      = 5;
  localparam int DECIMAL_BASE    = 10;
  localparam int MAX_PRINTED     = 60;

  localparam logic [OP_W-1:0] OP_RSVD_A = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD_B = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_C = 3'd7;

  localparam logic [CFG_IDX_W-1:0] CFG_ORDER [NUM_CFG] =
    '{REG_FUNC_SET, REG_DISP_CTL, REG_CLEAR, REG_ENTRY, REG_LINE0, REG_LINE1};

  typedef enum int {SET_ZERO, SET_ONES, SET_RANDOM, SET_DEFAULT} cfg_set_e;

  localparam cfg_set_e PHASE_SET [NUM_PHASES] =
    '{SET_ZERO, SET_ONES, SET_RANDOM, SET_RANDOM, SET_DEFAULT};
  localparam int PHASE_SEND_IDLE  [NUM_PHASES] = '{0, 71, 0, 37, 0};
  localparam int PHASE_RECV_STALL [NUM_PHASES] = '{0, 0, 71, 37, 0};

  typedef clni_out_t [0:3] byte_states_t;

  typedef struct packed {
    clni_in_t     req;
    logic         typed;
    logic [2:0]   n_typed;
    byte_states_t states;
  } dir_row_t;

  function automatic clni_out_t pin(input logic rs, input logic en,
                                    input logic [NIBBLE_W-1:0] nib,
                                    input logic [WAIT_W-1:0] ticks, input logic fin);
    clni_out_t s;
    s.register_select = rs;
    s.enable          = en;
    s.data_nibble     = nib;
    s.wait_ticks      = ticks;
    s.last            = fin;
    return s;
  endfunction

  localparam byte_states_t NO_STATES = '0;
  localparam int DIR_ROWS = 23;

  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{'{OP_INIT, 32'd0, 2'd0, 5'd0}, 1'b0, 3'd0, NO_STATES},
    // upper value bits ignored
    '{'{OP_CMD, 32'hFFFF_FF00, 2'd3, 5'd31}, 1'b1, 3'd4,
      {pin(1'b0, 1'b1, 4'h0, 5'd0, 1'b0), pin(1'b0, 1'b0, 4'h0, 5'd2, 1'b0),
       pin(1'b0, 1'b1, 4'h0, 5'd0, 1'b0), pin(1'b0, 1'b0, 4'h0, 5'd2, 1'b1)}},
    '{'{OP_DATA, 32'h0000_00FF, 2'd0, 5'd0}, 1'b1, 3'd4,
      {pin(1'b1, 1'b1, 4'hF, 5'd0, 1'b0), pin(1'b1, 1'b0, 4'hF, 5'd2, 1'b0),
       pin(1'b1, 1'b1, 4'hF, 5'd0, 1'b0), pin(1'b1, 1'b0, 4'hF, 5'd2, 1'b1)}},
    '{'{OP_CMD, 32'h5A5A_5AA5, 2'd1, 5'd10}, 1'b0, 3'd0, NO_STATES},
    '{'{OP_DATA, 32'hAAAA_AA5A, 2'd2, 5'd21}, 1'b0, 3'd0, NO_STATES},
    '{'{OP_CURSOR, 32'd0, 2'd0, 5'd0}, 1'b1, 3'd4,
      {pin(1'b0, 1'b1, 4'h8, 5'd0, 1'b0), pin(1'b0, 1'b0, 4'h8, 5'd2, 1'b0),
       pin(1'b0, 1'b1, 4'h0, 5'd0, 1'b0), pin(1'b0, 1'b0, 4'h0, 5'd2, 1'b1)}},
    '{'{OP_CURSOR, 32'd0, 2'd1, 5'd15}, 1'b1, 3'd4,
      {pin(1'b0, 1'b1, 4'hC, 5'd0, 1'b0), pin(1'b0, 1'b0, 4'hC, 5'd2, 1'b0),
       pin(1'b0, 1'b1, 4'hF, 5'd0, 1'b0), pin(1'b0, 1'b0, 4'hF, 5'd2, 1'b1)}},
    '{'{OP_CURSOR, 32'hFFFF_FFFF, 2'd1, 5'd0}, 1'b0, 3'd0, NO_STATES},
    // off-screen cursor and unknown operations give nothing
    '{'{OP_CURSOR, 32'd0, 2'd2, 5'd3}, 1'b1, 3'd0, NO_STATES},
    '{'{OP_CURSOR, 32'hFFFF_FFFF, 2'd3, 5'd31}, 1'b1, 3'd0, NO_STATES},
    '{'{OP_CURSOR, 32'd0, 2'd0, 5'd16}, 1'b1, 3'd0, NO_STATES},
    '{'{OP_CURSOR, 32'd0, 2'd1, 5'd31}, 1'b1, 3'd0, NO_STATES},
    '{'{OP_RSVD_A, 32'hFFFF_FFFF, 2'd3, 5'd31}, 1'b1, 3'd0, NO_STATES},
    '{'{OP_RSVD_B, 32'h0000_0041, 2'd0, 5'd0}, 1'b1, 3'd0, NO_STATES},
    '{'{OP_RSVD_C, 32'h1234_5678, 2'd1, 5'd5}, 1'b1, 3'd0, NO_STATES},
    // zero prints a single digit
    '{'{OP_NUMBER, 32'd0, 2'd0, 5'd0}, 1'b1, 3'd4,
      {pin(1'b1, 1'b1, 4'h3, 5'd0, 1'b0), pin(1'b1, 1'b0, 4'h3, 5'd2, 1'b0),
       pin(1'b1, 1'b1, 4'h0, 5'd0, 1'b0), pin(1'b1, 1'b0, 4'h0, 5'd2, 1'b1)}},
    '{'{OP_NUMBER, 32'hFFFF_FFFF, 2'd0, 5'd0}, 1'b0, 3'd0, NO_STATES},
    '{'{OP_NUMBER, 32'd9, 2'd0, 5'd0}, 1'b0, 3'd0, NO_STATES},
    '{'{OP_NUMBER, 32'd10, 2'd0, 5'd0}, 1'b0, 3'd0, NO_STATES},
    '{'{OP_NUMBER, 32'd1000000000, 2'd0, 5'd0}, 1'b0, 3'd0, NO_STATES},
    '{'{OP_NUMBER, 32'd999999999, 2'd0, 5'd0}, 1'b0, 3'd0, NO_STATES},
    // select pin still at data level from the number
    '{'{OP_INIT, 32'hFFFF_FFFF, 2'd3, 5'd31}, 1'b0, 3'd0, NO_STATES},
    '{'{OP_CMD, 32'h0000_00FF, 2'd3, 5'd31}, 1'b0, 3'd0, NO_STATES}
  };

  logic         clk          = 1'b0;
  logic         rst_n        = 1'b0;
  logic         in_valid     = 1'b0;
  logic         in_ready;
  clni_in_t     in_payload   = '0;
  logic         out_valid;
  logic         out_ready    = 1'b0;
  clni_out_t    out_payload;
  logic         cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [BYTE_W-1:0]    cfg_data  = '0;

  // expectation that travels with the request in flight
  logic         row_typed    = 1'b0;
  logic [2:0]   row_n_typed  = '0;
  byte_states_t row_states   = '0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int quiet_cycles   = 0;

  logic [BYTE_W-1:0] cmd_regs [NUM_CFG];
  logic              rs_level;
  clni_out_t         predicted_states [$];
  clni_out_t         pin_states_due [$];

  char_lcd_nibble_interface uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_payload   (in_payload),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_payload  (out_payload),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic void strobe_nibble(input logic rs, input logic [NIBBLE_W-1:0] nib,
                                        input logic [WAIT_W-1:0] pre_wait);
    predicted_states.push_back(pin(rs, 1'b1, nib, pre_wait, 1'b0));
    predicted_states.push_back(pin(rs, 1'b0, nib, STROBE_WAIT, 1'b0));
  endfunction

  function automatic void put_byte(input logic rs, input logic [BYTE_W-1:0] b,
                                   input logic [WAIT_W-1:0] pre_wait);
    rs_level = rs;
    strobe_nibble(rs, b[7:4], pre_wait);
    strobe_nibble(rs, b[3:0], WAIT_NONE);
  endfunction

  function automatic void predict_pin_states(input clni_in_t req);
    logic [VALUE_W-1:0]  rest;
    logic [DIGIT_W-1:0]  digs [$];
    logic [BYTE_W-1:0]   base;
    clni_out_t           fin;
    predicted_states.delete();
    case (req.operation)
      OP_INIT: begin
        strobe_nibble(rs_level, cmd_regs[REG_FUNC_SET][7:4], INIT_WAIT);
        put_byte(1'b0, cmd_regs[REG_FUNC_SET], WAIT_NONE);
        put_byte(1'b0, cmd_regs[REG_DISP_CTL], WAIT_ONE);
        put_byte(1'b0, cmd_regs[REG_CLEAR], WAIT_ONE);
        put_byte(1'b0, cmd_regs[REG_ENTRY], STROBE_WAIT);
      end
      OP_CMD:  put_byte(1'b0, req.value[BYTE_W-1:0], WAIT_NONE);
      OP_DATA: put_byte(1'b1, req.value[BYTE_W-1:0], WAIT_NONE);
      OP_CURSOR: begin
        if (req.line < NUM_LINES && req.position < NUM_COLS) begin
          base = (req.line == '0) ? cmd_regs[REG_LINE0] : cmd_regs[REG_LINE1];
          put_byte(1'b0, BYTE_W'(req.position) + base, WAIT_NONE);
        end
      end
      OP_NUMBER: begin
        rest = req.value;
        do begin
          digs.push_front(DIGIT_W'(rest % DECIMAL_BASE));
          rest = rest / DECIMAL_BASE;
        end while (rest != 0);
        foreach (digs[k]) put_byte(1'b1, ASCII_ZERO + BYTE_W'(digs[k]), WAIT_NONE);
      end
      default: ;
    endcase
    if (predicted_states.size() > 0) begin
      fin = predicted_states[predicted_states.size() - 1];
      fin.last = 1'b1;
      predicted_states[predicted_states.size() - 1] = fin;
    end
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatch_count < MAX_PRINTED)
      $display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_pin_state(input clni_out_t got);
    clni_out_t want;
    if (pin_states_due.size() == 0) begin
      report_mismatch("pin state with nothing due", 32'(got), 32'd0);
    end else begin
      want = pin_states_due.pop_front();
      if (got.register_select !== want.register_select)
        report_mismatch("register_select", 32'(got.register_select),
                        32'(want.register_select));
      if (got.enable !== want.enable)
        report_mismatch("enable", 32'(got.enable), 32'(want.enable));
      if (got.data_nibble !== want.data_nibble)
        report_mismatch("data_nibble", 32'(got.data_nibble), 32'(want.data_nibble));
      if (got.wait_ticks !== want.wait_ticks)
        report_mismatch("wait_ticks", 32'(got.wait_ticks), 32'(want.wait_ticks));
      if (got.last !== want.last)
        report_mismatch("last", 32'(got.last), 32'(want.last));
    end
  endtask

  // transfer monitor and predictor upkeep
  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (cmd_regs[k]) cmd_regs[k] = CFG_RESET[k];
      rs_level = 1'b0;
    end else begin
      if (out_valid && out_ready) check_pin_state(out_payload);
      if (in_valid && in_ready) begin
        predict_pin_states(in_payload);
        if (row_typed) begin
          for (int k = 0; k < row_n_typed; k++) pin_states_due.push_back(row_states[k]);
        end else begin
          foreach (predicted_states[k]) pin_states_due.push_back(predicted_states[k]);
        end
      end
      if (cfg_write_en && cfg_index < NUM_CFG) cmd_regs[cfg_index] = cfg_data;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("char_lcd_nibble_interface_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(input clni_in_t req, input logic typed,
                              input logic [2:0] n_typed, input byte_states_t states);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid    <= 1'b1;
    in_payload  <= req;
    row_typed   <= typed;
    row_n_typed <= n_typed;
    row_states  <= states;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pin_states_due.size() != 0);
  endtask

  task automatic load_cfg(input cfg_set_e setting);
    logic [BYTE_W-1:0] d;
    foreach (CFG_ORDER[k]) begin
      case (setting)
        SET_ZERO:    d = '0;
        SET_ONES:    d = '1;
        SET_DEFAULT: d = CFG_RESET[k];
        default:     d = BYTE_W'($urandom);
      endcase
      cfg_write_en <= 1'b1;
      cfg_index    <= CFG_ORDER[k];
      cfg_data     <= d;
      @(posedge clk);
    end
    cfg_write_en <= 1'b0;
  endtask

  function automatic logic [VALUE_W-1:0] rand_number();
    longint unsigned span;
    int              n_dig;
    n_dig = ($urandom_range(99) < 75) ? $urandom_range(1, 3) : $urandom_range(4, NUM_DIGITS);
    span  = 1;
    repeat (n_dig) span = span * DECIMAL_BASE;
    return VALUE_W'({$urandom, $urandom} % span);
  endfunction

  function automatic clni_in_t rand_request();
    clni_in_t r;
    int       pick;
    pick       = $urandom_range(99);
    r.value    = $urandom;
    r.line     = LINE_W'($urandom_range(3));
    r.position = POS_W'($urandom_range(31));
    if (pick < 8) begin
      r.operation = OP_INIT;
    end else if (pick < 28) begin
      r.operation = OP_CMD;
    end else if (pick < 48) begin
      r.operation = OP_DATA;
    end else if (pick < 70) begin
      r.operation = OP_CURSOR;
      if ($urandom_range(99) < 85) begin
        r.line     = LINE_W'($urandom_range(NUM_LINES - 1));
        r.position = POS_W'($urandom_range(NUM_COLS - 1));
      end
    end else if (pick < 95) begin
      r.operation = OP_NUMBER;
      r.value     = rand_number();
    end else begin
      r.operation = OP_W'($urandom_range(OP_RSVD_A, OP_RSVD_C));
    end
    return r;
  endfunction

  initial begin
    clni_in_t r;
    int       sent;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[i])
      send_request(DIRECTED[i].req, DIRECTED[i].typed, DIRECTED[i].n_typed,
                   DIRECTED[i].states);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clk);
      load_cfg(PHASE_SET[ph]);
      send_idle_pct  = PHASE_SEND_IDLE[ph];
      recv_stall_pct = PHASE_RECV_STALL[ph];
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        if ($urandom_range(99) < 3) wait_for_drain();
        r = rand_request();
        send_request(r, 1'b0, 3'd0, NO_STATES);
        if (!(r.operation > OP_NUMBER || (r.operation == OP_CURSOR &&
              (r.line >= NUM_LINES || r.position >= NUM_COLS))))
          sent++;
      end
    end

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("char_lcd_nibble_interface_tb: PASS");
    end else begin
      $display("char_lcd_nibble_interface_tb: FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/clni_pkg.sv
rtl/clni_front.sv
rtl/clni_queue.sv
rtl/clni_back.sv
rtl/char_lcd_nibble_interface.sv
rtl/clni_checker.sv
verif/char_lcd_nibble_interface_tb.sv
